### rtl/gqs_pkg.sv
// Shared types, constants and a helper function for the Q-set size block.
`timescale 1ns / 1ps

package gqs_pkg;

	localparam int VERTICES = 64;
	localparam int ROW_SLOTS = 64;
	localparam int ROW_W = 64;
	localparam int IDX_W = 6;
	localparam int CNT_W = 7;
	localparam int CHUNK_W = 8;
	localparam int CHUNKS = ROW_W / CHUNK_W;
	localparam int CHUNK_IDX_W = $clog2(CHUNKS);

	localparam logic [ROW_W-1:0] VMASK = {ROW_W{1'b1}} >> (ROW_W - VERTICES);

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_COUNT,
		ST_DONE
	} gqs_state_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [ROW_W-1:0] wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

	function automatic logic [3:0] popcount8(input logic [CHUNK_W-1:0] x);
		logic [3:0] c;
		c = '0;
		for (int i = 0; i < CHUNK_W; i++) begin
			c = c + {3'b000, x[i]};
		end
		return c;
	endfunction

endpackage

### rtl/gqs_adj_ram.sv
// Adjacency row memory with one write and one registered read port, cleared by valid bits.
`timescale 1ns / 1ps

module gqs_adj_ram
	import gqs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  ram_req_t         req,
	output logic [ROW_W-1:0] rdata
);

	logic [ROW_W-1:0]     mem [ROW_SLOTS];
	logic [ROW_SLOTS-1:0] valid_q;
	logic [ROW_W-1:0]     rdata_q;
	logic                 rvalid_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				rvalid_q <= valid_q[req.raddr];
			end
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

### rtl/gqs_pick.sv
// Lowest set bit search that selects the next vertex to expand.
`timescale 1ns / 1ps

module gqs_pick
	import gqs_pkg::*;
(
	input  logic [ROW_W-1:0] pending,
	output logic             found,
	output logic [IDX_W-1:0] index
);

	logic [ROW_W-1:0] iso;

	assign iso   = pending & (~pending + ROW_W'(1));
	assign found = |pending;

	always_comb begin
		index = '0;
		for (int i = 0; i < ROW_W; i++) begin
			if (iso[i]) begin
				index = index | IDX_W'(i);
			end
		end
	end

endmodule

### rtl/graph_q_set_size.sv
// Q-set size engine: holds adjacency rows and answers reachability count queries.
// A load item (cmd 0) writes one adjacency row. A query item (cmd 1)
// walks the graph from the start vertex, expanding one vertex of the set per cycle
// through the single read port of the adjacency memory, then counts the reached
// vertices outside the set eight bits per cycle. A query expands at most 63 vertices.
// The adjacency memory reads as an empty graph straight after reset, with no clearing
// pass. The finished count sits in an output register, so the next item is taken while
// it waits; a query that finishes while the previous count is still held there waits
// in its final state until that count is taken.
`timescale 1ns / 1ps

module graph_q_set_size
	import gqs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  logic [IDX_W-1:0]      row_index,
	input  logic [ROW_W-1:0]      row_bits,
	input  logic [ROW_W-1:0]      set_bits,
	input  logic [IDX_W-1:0]      start_vertex,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CNT_W-1:0]      q_count
);

	gqs_state_t state_q, state_d;

	ram_req_t                 req;
	logic [ROW_W-1:0]         rdata;
	logic [ROW_W-1:0]         set_q;
	logic [ROW_W-1:0]         vbit_q;
	logic [ROW_W-1:0]         reached_q;
	logic [ROW_W-1:0]         expanded_q;
	logic [ROW_W-1:0]         reached_next;
	logic [ROW_W-1:0]         pending;
	logic                     found;
	logic [IDX_W-1:0]         pick_idx;
	logic [ROW_W-1:0]         word_q;
	logic [CHUNK_IDX_W-1:0]   chunk_q;
	logic [CNT_W-1:0]         count_q;
	logic                     out_valid_q;
	logic [CNT_W-1:0]         q_count_q;
	logic                     accept;
	logic                     start_out;
	logic                     out_load;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign start_out = ({1'b0, start_vertex} >= (IDX_W + 1)'(VERTICES));
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	assign reached_next = reached_q | rdata;
	assign pending      = reached_next & set_q & ~vbit_q & ~expanded_q;

	gqs_pick u_pick (
		.pending (pending),
		.found   (found),
		.index   (pick_idx)
	);

	gqs_adj_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (rdata)
	);

	always_comb begin
		state_d   = state_q;
		req.we    = 1'b0;
		req.waddr = row_index;
		req.wdata = row_bits & VMASK;
		req.re    = 1'b0;
		req.raddr = start_vertex;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd == CMD_LOAD) begin
						req.we = ({1'b0, row_index} < (IDX_W + 1)'(VERTICES));
					end else if (start_out) begin
						state_d = ST_DONE;
					end else begin
						req.re  = 1'b1;
						state_d = ST_EXPAND;
					end
				end
			end
			ST_EXPAND: begin
				if (found) begin
					req.re    = 1'b1;
					req.raddr = pick_idx;
				end else begin
					state_d = ST_COUNT;
				end
			end
			ST_COUNT: begin
				if (chunk_q == CHUNK_IDX_W'(CHUNKS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd == CMD_QUERY) begin
					set_q      <= set_bits & VMASK;
					vbit_q     <= ROW_W'(1) << start_vertex;
					reached_q  <= '0;
					expanded_q <= '0;
					count_q    <= '0;
					chunk_q    <= '0;
				end
			end
			ST_EXPAND: begin
				reached_q <= reached_next;
				if (found) begin
					expanded_q <= expanded_q | (ROW_W'(1) << pick_idx);
				end else begin
					word_q <= reached_next & ~set_q & ~vbit_q;
				end
			end
			ST_COUNT: begin
				count_q <= count_q + CNT_W'(popcount8(word_q[CHUNK_W-1:0]));
				word_q  <= word_q >> CHUNK_W;
				chunk_q <= chunk_q + CHUNK_IDX_W'(1);
			end
			default: begin
			end
		endcase
		if (out_load) begin
			q_count_q <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign q_count   = q_count_q;

endmodule
